// ===== design/stbs_pkg.sv =====
// Shared types and constants for the sorted-table lower-bound search block.
// No dependencies; compiled first.
`default_nettype none

package stbs_pkg;

    localparam int IDX_W       = 10;
    localparam int TABLE_DEPTH = 1 << IDX_W;
    localparam int CNT_W       = IDX_W + 1;
    localparam int DATA_W      = 32;

    typedef enum logic
    {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_FINAL,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== design/stbs_if.sv =====
// Channel interfaces: item requests, results and the entry_count write port.
// Depends on stbs_pkg.
`default_nettype none

interface stbs_in_if;
    import stbs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;

    modport source (output valid, action, entry_index, entry_value, search_key, input ready);
    modport sink   (input valid, action, entry_index, entry_value, search_key, output ready);
    modport mon    (input valid, ready, action, entry_index, entry_value, search_key);
endinterface

interface stbs_out_if;
    import stbs_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [CNT_W-1:0]  lower_bound_index;
    logic [DATA_W-1:0] hit_total;

    modport source (output valid, found, lower_bound_index, hit_total, input ready);
    modport sink   (input valid, found, lower_bound_index, hit_total, output ready);
    modport mon    (input valid, ready, found, lower_bound_index, hit_total);
endinterface

interface stbs_cfg_if;
    import stbs_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
    modport mon    (input valid, ready, data);
endinterface

`default_nettype wire

// ===== design/stbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/sorted_table_binary_search.sv =====
// Top level: sorted table in one RAM, lower-bound search sequencer, result register.
// Depends on stbs_pkg, stbs_if (interfaces) and stbs_ram.
//
//   channel  dir  handshake      payload
//   cfg      in   valid/ready    data = entry_count (always ready)
//   req      in   valid/ready    action, entry_index, entry_value, search_key
//   rsp      out  valid/ready    found, lower_bound_index, hit_total
//
// Load request: accepted in ST_IDLE, writes the RAM, no result.
// Query: the accept cycle issues the first probe, then one RAM probe per cycle,
//   floor(log2(count)) or one more probes, plus at most one confirm read in
//   ST_FINAL, then ST_DONE posts the result. The RAM read latency in the
//   halving loop sets the rate.
// A finished result sits in the output register; the next request is taken
//   while it waits. Reset clears state, result valid, entry_count and hit counter.
`default_nettype none

module sorted_table_binary_search (
    input  wire logic   clk,
    input  wire logic   rst_n,
    stbs_cfg_if.sink    cfg,
    stbs_in_if.sink     req,
    stbs_out_if.source  rsp
);
    import stbs_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         entry_count_reg;
    logic [CNT_W-1:0]         left_reg, left_next;
    logic [CNT_W-1:0]         right_reg, right_next;
    logic [IDX_W-1:0]         mid_reg, mid_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     hit_reg, hit_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic                     found_reg, found_next;
    logic [CNT_W-1:0]         lb_reg, lb_next;
    logic [DATA_W-1:0]        hit_cnt_reg, hit_cnt_next;

    logic                     ram_we;
    logic                     ram_re;
    logic [IDX_W-1:0]         ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic [CNT_W-1:0]         count_sat;
    logic                     probe_lt;
    logic [CNT_W-1:0]         probe_left;
    logic [CNT_W-1:0]         probe_right;
    logic [CNT_W-1:0]         probe_sum;

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req.entry_index),
        .wdata (req.entry_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_sat = (entry_count_reg > CNT_W'(TABLE_DEPTH)) ?
                       CNT_W'(TABLE_DEPTH) : entry_count_reg;

    // One halving step on the entry read at mid_reg.
    assign probe_lt    = $signed(ram_rdata) < key_reg;
    assign probe_left  = probe_lt ? ({1'b0, mid_reg} + CNT_W'(1)) : left_reg;
    assign probe_right = probe_lt ? right_reg : {1'b0, mid_reg};
    assign probe_sum   = probe_left + ((probe_right - probe_left) >> 1);

    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        found_next     = found_reg;
        lb_next        = lb_reg;
        hit_cnt_next   = hit_cnt_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = mid_reg;
        req.ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.action == ACT_LOAD)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        key_next   = req.search_key;
                        left_next  = '0;
                        right_next = count_sat;
                        if (count_sat != '0)
                        begin
                            mid_next   = count_sat[IDX_W:1];
                            ram_re     = 1'b1;
                            ram_raddr  = count_sat[IDX_W:1];
                            state_next = ST_SEARCH;
                        end
                        else
                        begin
                            hit_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                left_next  = probe_left;
                right_next = probe_right;
                if (probe_left < probe_right)
                begin
                    mid_next  = probe_sum[IDX_W-1:0];
                    ram_re    = 1'b1;
                    ram_raddr = probe_sum[IDX_W-1:0];
                end
                else if (!probe_lt)
                begin
                    // converged on the entry just read
                    hit_next   = ram_rdata == key_reg;
                    state_next = ST_DONE;
                end
                else if (probe_left < count_sat)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = probe_left[IDX_W-1:0];
                    state_next = ST_FINAL;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end
            end

            ST_FINAL:
            begin
                hit_next   = ram_rdata == key_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    found_next     = hit_reg;
                    lb_next        = left_reg;
                    if (hit_reg && (hit_cnt_reg != '1))
                    begin
                        hit_cnt_next = hit_cnt_reg + DATA_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rsp_valid_reg   <= 1'b0;
            hit_cnt_reg     <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            hit_cnt_reg   <= hit_cnt_next;
            if (cfg.valid)
            begin
                entry_count_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        hit_reg   <= hit_next;
        found_reg <= found_next;
        lb_reg    <= lb_next;
    end

    assign cfg.ready             = 1'b1;
    assign rsp.valid             = rsp_valid_reg;
    assign rsp.found             = found_reg;
    assign rsp.lower_bound_index = lb_reg;
    assign rsp.hit_total         = hit_cnt_reg;

endmodule

`default_nettype wire

// ===== design/stbs_checker.sv =====
// Port-level assertions for sorted_table_binary_search, attached by bind.
// Depends on stbs_pkg; taps the top level's interface ports.
`default_nettype none

module stbs_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         req_action,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic                         rsp_found,
    input wire logic [stbs_pkg::CNT_W-1:0]   rsp_lower_bound_index,
    input wire logic [stbs_pkg::DATA_W-1:0]  rsp_hit_total
);
    import stbs_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
            && $stable(rsp_lower_bound_index) && $stable(rsp_hit_total))
        else $error("result changed while stalled");

    a_lb_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_lower_bound_index <= CNT_W'(TABLE_DEPTH))
        else $error("lower bound beyond table");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_hit_total != '0)
        else $error("hit reported with zero hit total");

    // a query occupies the sequencer for at least the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == ACT_QUERY) |=> !req_ready)
        else $error("request taken during a search");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .req_valid             (req.valid),
    .req_ready             (req.ready),
    .req_action            (req.action),
    .rsp_valid             (rsp.valid),
    .rsp_ready             (rsp.ready),
    .rsp_found             (rsp.found),
    .rsp_lower_bound_index (rsp.lower_bound_index),
    .rsp_hit_total         (rsp.hit_total)
);

`default_nettype wire

// ===== verif/tb_sorted_table_binary_search.sv =====
// Testbench for sorted_table_binary_search: random table loads and lower-bound queries,
// checked against a built-in search predictor. Needs stbs_pkg, stbs_if and the RTL.
`timescale 1ns / 1ps

typedef struct packed
{
    logic                        found;
    logic [stbs_pkg::CNT_W-1:0]  lower_bound_index;
    logic [stbs_pkg::DATA_W-1:0] hit_total;
} search_answer_t;

class search_tracker;
    logic signed [stbs_pkg::DATA_W-1:0] entries [stbs_pkg::TABLE_DEPTH];
    logic [stbs_pkg::DATA_W-1:0]        hit_count;
    logic [stbs_pkg::CNT_W-1:0]         entry_count;
    search_answer_t                     pending_answers [$];
    int                                 errors;

    function new();
        hit_count   = '0;
        entry_count = '0;
        errors      = 0;
        foreach (entries[i])
            entries[i] = '0;
    endfunction

    function void set_count(logic [stbs_pkg::CNT_W-1:0] value);
        entry_count = value;
    endfunction

    function int unsigned span();
        return (entry_count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : entry_count;
    endfunction

    // Loads update the table copy; queries run the halving search and queue the answer.
    function void note_request(stbs_pkg::action_t act,
                               logic [stbs_pkg::IDX_W-1:0] idx,
                               logic signed [stbs_pkg::DATA_W-1:0] value,
                               logic signed [stbs_pkg::DATA_W-1:0] key);
        int unsigned    n;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        bit             hit;
        search_answer_t ans;
        if (act == stbs_pkg::ACT_LOAD)
        begin
            entries[idx] = value;
            return;
        end
        n  = span();
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (entries[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        hit = (lo < n) && (entries[lo] == key);
        if (hit && hit_count != '1)
            hit_count = hit_count + 1;
        ans.found             = hit;
        ans.lower_bound_index = lo[stbs_pkg::CNT_W-1:0];
        ans.hit_total         = hit_count;
        pending_answers.push_back(ans);
    endfunction

    function void check_answer(logic found, logic [stbs_pkg::CNT_W-1:0] lb,
                               logic [stbs_pkg::DATA_W-1:0] hits);
        search_answer_t exp_ans;
        if (pending_answers.size() == 0)
        begin
            $display("%0t: unexpected result found=%0d lower_bound_index=%0d hit_total=%0d",
                     $time, found, lb, hits);
            errors++;
            return;
        end
        exp_ans = pending_answers.pop_front();
        if (found !== exp_ans.found)
        begin
            $display("%0t: found mismatch: expected %0d, actual %0d",
                     $time, exp_ans.found, found);
            errors++;
        end
        if (lb !== exp_ans.lower_bound_index)
        begin
            $display("%0t: lower_bound_index mismatch: expected %0d, actual %0d",
                     $time, exp_ans.lower_bound_index, lb);
            errors++;
        end
        if (hits !== exp_ans.hit_total)
        begin
            $display("%0t: hit_total mismatch: expected %0d, actual %0d",
                     $time, exp_ans.hit_total, hits);
            errors++;
        end
    endfunction

    function bit idle();
        return pending_answers.size() == 0;
    endfunction
endclass

module tb_sorted_table_binary_search;
    import stbs_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic clk;
    logic rst_n;
    bit   steady;
    int   hold_len;
    int   idle_cycles;

    search_tracker tracker;

    stbs_in_if  req_ch ();
    stbs_out_if rsp_ch ();
    stbs_cfg_if cfg_ch ();

    sorted_table_binary_search DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function logic signed [DATA_W-1:0] choose_key();
        int unsigned n;
        int          r;
        n = tracker.span();
        r = $urandom_range(0, 9);
        if (n > 0 && r < 5)
            return tracker.entries[$urandom_range(0, n - 1)];
        if (n > 0 && r < 7)
            return tracker.entries[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        if (r == 7)
            return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
        return $urandom;
    endfunction

    task automatic send_request(action_t act, logic [IDX_W-1:0] idx,
                                logic signed [DATA_W-1:0] value,
                                logic signed [DATA_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.action      = act;
        req_ch.entry_index = idx;
        req_ch.entry_value = value;
        req_ch.search_key  = key;
        req_ch.valid       = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.note_request(act, idx, value, key);
    endtask

    task automatic query(logic signed [DATA_W-1:0] key);
        send_request(ACT_QUERY, IDX_W'($urandom), DATA_W'($urandom), key);
    endtask

    task automatic load(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] value);
        send_request(ACT_LOAD, idx, value, DATA_W'($urandom));
    endtask

    // let the block finish every query, and any load still in flight
    task automatic settle_block();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (!tracker.idle())
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] value);
        @(negedge clk);
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        tracker.set_count(value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // result sink: short random stalls, plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (hold_len - 1) @(negedge clk);
                hold_len = 0;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                stall_left   = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            tracker.check_answer(rsp_ch.found, rsp_ch.lower_bound_index, rsp_ch.hit_total);
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        longint           acc;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0] idx;
        int unsigned      n;
        logic [CNT_W-1:0] mixed_counts [6];

        tracker            = new();
        steady             = 1'b0;
        hold_len           = 0;
        idle_cycles        = 0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_LOAD;
        req_ch.entry_index = '0;
        req_ch.entry_value = '0;
        req_ch.search_key  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // empty search: nothing is read from the table
        write_count('0);
        query(KEY_MIN);
        query(KEY_MAX);
        query('0);

        // ascending fill with duplicates, both extremes present
        acc = KEY_MIN;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == TABLE_DEPTH - 1)
                value = KEY_MAX;
            else
            begin
                if (i > 0 && $urandom_range(0, 4) != 0)
                    acc += $urandom_range(1, 4000000);
                value = DATA_W'(acc);
            end
            load(i[IDX_W-1:0], value);
        end
        settle_block();

        write_count(CNT_W'(TABLE_DEPTH));
        query(KEY_MIN);
        query(KEY_MAX);
        query(KEY_MAX - 1);
        query(tracker.entries[512]);
        query(tracker.entries[512] + 1);
        for (int i = 0; i < 300; i++)
        begin
            if (i == 100)
                hold_len = HOLD_CYCLES;
            query(choose_key());
        end
        settle_block();

        write_count(CNT_W'(1));
        query(tracker.entries[0]);
        query(KEY_MAX);
        query(KEY_MIN);
        for (int i = 0; i < 20; i++)
            query(choose_key());
        settle_block();

        // count above the table depth saturates; run this stretch without idling
        steady = 1'b1;
        write_count('1);
        query(KEY_MAX);
        query(tracker.entries[TABLE_DEPTH - 2]);
        for (int i = 0; i < 50; i++)
            query(choose_key());
        settle_block();
        steady = 1'b0;

        // loads between queries: a query must see the load just before it
        write_count(CNT_W'(2));
        query(tracker.entries[1]);
        load(IDX_W'(1), tracker.entries[0] - 5);
        query(tracker.entries[1]);
        load('0, KEY_MAX);
        query(KEY_MAX);
        settle_block();

        // mixed loads and queries, table no longer kept in order
        mixed_counts[0] = '0;
        mixed_counts[1] = CNT_W'(7);
        mixed_counts[2] = CNT_W'($urandom_range(1, TABLE_DEPTH));
        mixed_counts[3] = CNT_W'(TABLE_DEPTH - 1);
        mixed_counts[4] = CNT_W'($urandom_range(TABLE_DEPTH + 1, (1 << CNT_W) - 1));
        mixed_counts[5] = CNT_W'(TABLE_DEPTH);
        for (int p = 0; p < 6; p++)
        begin
            steady = (p == 2);
            write_count(mixed_counts[p]);
            n = tracker.span();
            for (int i = 0; i < 90; i++)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    idx = IDX_W'((n > 0 && $urandom_range(0, 3) != 0) ?
                                 $urandom_range(0, n - 1) : $urandom);
                    case ($urandom_range(0, 2))
                        0: value = tracker.entries[$urandom_range(0, TABLE_DEPTH - 1)];
                        1: value = tracker.entries[idx] + $urandom_range(0, 7) - 3;
                        default: value = $urandom;
                    endcase
                    load(idx, value);
                end
                else
                    query(choose_key());
            end
            settle_block();
        end
        steady = 1'b0;

        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
